// ===== design/timestamp_kway_merge_defines.svh =====
// assertion macros shared by the merge block
`ifndef TIMESTAMP_KWAY_MERGE_DEFINES_SVH
`define TIMESTAMP_KWAY_MERGE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TKM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TKM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/tkm_pkg.sv =====
`timescale 1ns / 1ps

package tkm_pkg;

	// fixed field and port widths
	localparam int SRC_PORT_W = 3;
	localparam int NUM_FIELDS = 8;
	localparam int S_USER_W   = SRC_PORT_W + 1;
	localparam int M_USER_W   = SRC_PORT_W + 1;
	localparam int CFG_W      = 4;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	// register map (word index)
	localparam logic REG_ACTIVE_SOURCES = 1'b0;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

	// req_type codes
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_END    = 1'b1;

	// item class decided by the front
	typedef enum logic [1:0] {
		KIND_RECORD,
		KIND_END,
		KIND_DROP
	} item_kind_t;

	typedef struct packed {
		item_kind_t            kind;
		logic [SRC_PORT_W-1:0] source;
	} item_ctl_t;

	typedef struct packed {
		logic                  has_record;
		logic                  merge_done;
		logic [SRC_PORT_W-1:0] source;
	} res_ctl_t;

endpackage

// ===== design/tkm_front.sv =====
`timescale 1ns / 1ps

module tkm_front import tkm_pkg::*; #(
	parameter int FIELD_BITS = 32,
	parameter int CMP_W      = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [CMP_W-1:0]               live_count,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [NUM_FIELDS*FIELD_BITS-1:0] s_tdata,
	input  logic [S_USER_W-1:0]            s_tuser,
	output logic                           q_valid,
	output item_ctl_t                      q_ctl,
	output logic [NUM_FIELDS*FIELD_BITS-1:0] q_data,
	input  logic                           q_pop
);

	localparam int DATA_W = NUM_FIELDS * FIELD_BITS;
	localparam logic [1:0] QUEUE_EMPTY = 2'd0;
	localparam logic [1:0] QUEUE_FULL  = 2'd2;

	item_ctl_t          in_ctl;
	logic [CMP_W-1:0]   src_ext;
	logic               push;
	logic               pop;

	item_ctl_t          ctl_q [2];
	logic [DATA_W-1:0]  data_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	// classify: sources outside the taking-part range are marked for dropping here
	assign src_ext = CMP_W'(s_tuser[SRC_PORT_W:1]);

	always_comb begin
		in_ctl.source = s_tuser[SRC_PORT_W:1];
		if (src_ext >= live_count) begin
			in_ctl.kind = KIND_DROP;
		end else if (s_tuser[0] == REQ_END) begin
			in_ctl.kind = KIND_END;
		end else begin
			in_ctl.kind = KIND_RECORD;
		end
	end

	// two-entry queue toward the back
	assign s_tready = (count_q != QUEUE_FULL);
	assign q_valid  = (count_q != QUEUE_EMPTY);
	assign push     = s_tvalid & s_tready;
	assign pop      = q_pop & q_valid;
	assign q_ctl    = ctl_q[rd_ptr_q];
	assign q_data   = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]  <= in_ctl;
			data_q[wr_ptr_q] <= s_tdata;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= QUEUE_EMPTY;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/tkm_back.sv =====
`timescale 1ns / 1ps

module tkm_back import tkm_pkg::*; #(
	parameter int SOURCES    = 8,
	parameter int FIELD_BITS = 32,
	parameter int CMP_W      = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [CMP_W-1:0]               live_count,
	input  logic                           q_valid,
	input  item_ctl_t                      q_ctl,
	input  logic [NUM_FIELDS*FIELD_BITS-1:0] q_data,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [NUM_FIELDS*FIELD_BITS-1:0] m_tdata,
	output logic [M_USER_W-1:0]            m_tuser,
	output logic                           m_tlast
);

	localparam int DATA_W = NUM_FIELDS * FIELD_BITS;
	localparam int SRC_W  = $clog2(SOURCES);
	localparam int LEAVES = 1 << SRC_W;
	localparam int NODES  = 2 * LEAVES - 1;

	logic [DATA_W-1:0]     head_q [SOURCES];
	logic [SOURCES-1:0]    valid_q;
	logic [SOURCES-1:0]    ended_q;
	logic                  done_q;

	logic                  out_valid_q;
	res_ctl_t              out_ctl_q;
	logic [DATA_W-1:0]     out_data_q;

	logic                  step;
	logic                  work;
	logic [CMP_W-1:0]      src_ext;
	logic [SRC_W-1:0]      idx;
	logic                  slot_free;
	logic                  wr_rec;
	logic                  wr_end;
	logic [SOURCES-1:0]    nv;
	logic [SOURCES-1:0]    ne;
	logic [SOURCES-1:0]    clr;
	logic                  all_ready;
	logic                  found;
	logic                  finished;
	logic                  emit;
	logic                  done_now;
	logic                  produce;

	logic                  node_v [NODES];
	logic [FIELD_BITS-1:0] node_t [NODES];
	logic [SRC_W-1:0]      node_i [NODES];
	logic [SRC_W-1:0]      best;
	logic [CMP_W-1:0]      best_ext;
	logic [DATA_W-1:0]     best_data;

	// one queue entry per cycle whenever the output register can take a result
	assign step    = q_valid & (~out_valid_q | m_tready);
	assign q_pop   = step;
	assign work    = step & ~done_q;
	assign src_ext = CMP_W'(q_ctl.source);
	assign idx     = src_ext[SRC_W-1:0];

	always_comb begin
		slot_free = 1'b0;
		if (q_ctl.kind != KIND_DROP) begin
			slot_free = ~valid_q[idx] & ~ended_q[idx];
		end
		wr_rec = (q_ctl.kind == KIND_RECORD) & slot_free;
		wr_end = (q_ctl.kind == KIND_END) & slot_free;
	end

	// state after the item, readiness over taking-part sources, tree leaves
	always_comb begin
		all_ready = 1'b1;
		found     = 1'b0;
		finished  = 1'b1;
		for (int i = 0; i < LEAVES; i++) begin
			node_v[LEAVES-1+i] = 1'b0;
			node_t[LEAVES-1+i] = '0;
			node_i[LEAVES-1+i] = SRC_W'(i);
		end
		for (int i = 0; i < SOURCES; i++) begin
			nv[i] = valid_q[i] | (wr_rec & (idx == SRC_W'(i)));
			ne[i] = ended_q[i] | (wr_end & (idx == SRC_W'(i)));
			if (CMP_W'(i) < live_count) begin
				all_ready = all_ready & (ne[i] | nv[i]);
				found     = found | nv[i];
				finished  = finished & ne[i] & ~nv[i];
				node_v[LEAVES-1+i] = nv[i];
			end
			node_t[LEAVES-1+i] = (wr_rec & (idx == SRC_W'(i))) ?
				q_data[FIELD_BITS-1:0] : head_q[i][FIELD_BITS-1:0];
		end
		// min tree, left (lower index) wins on equal timestamps
		for (int k = LEAVES - 2; k >= 0; k--) begin
			if (node_v[2*k+1] & (~node_v[2*k+2] | (node_t[2*k+1] <= node_t[2*k+2]))) begin
				node_v[k] = node_v[2*k+1];
				node_t[k] = node_t[2*k+1];
				node_i[k] = node_i[2*k+1];
			end else begin
				node_v[k] = node_v[2*k+2];
				node_t[k] = node_t[2*k+2];
				node_i[k] = node_i[2*k+2];
			end
		end
	end

	assign best     = node_i[0];
	assign best_ext = CMP_W'(best);
	assign emit     = all_ready & found;
	assign done_now = finished & ~emit;
	assign produce  = work & (emit | done_now);

	// winning record, bypassing a head written in this same step
	always_comb begin
		best_data = (wr_rec & (idx == best)) ? q_data : head_q[best];
		for (int i = 0; i < SOURCES; i++) begin
			clr[i] = emit & (best == SRC_W'(i));
		end
	end

	// head records
	always_ff @(posedge clk) begin
		if (work & wr_rec) begin
			head_q[idx] <= q_data;
		end
	end

	// per-source flags and end of merge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ended_q <= '0;
			done_q  <= 1'b0;
		end else if (work) begin
			valid_q <= nv & ~clr;
			ended_q <= ne;
			if (done_now) done_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			out_ctl_q.has_record <= emit;
			out_ctl_q.merge_done <= done_now;
			out_ctl_q.source     <= emit ? best_ext[SRC_PORT_W-1:0] : '0;
			out_data_q           <= emit ? best_data : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_ctl_q.source, out_ctl_q.has_record};
	assign m_tlast  = out_ctl_q.merge_done;

endmodule

// ===== design/timestamp_kway_merge.sv =====
`timescale 1ns / 1ps
`include "timestamp_kway_merge_defines.svh"

// Timestamp k-way merge: takes one beat per cycle while the output is not stalled,
// from up to SOURCES interleaved time-sorted record streams and returns them as one
// stream ordered by timestamp (lowest source index first on equal timestamps). Each
// input beat is a record or an end mark for one source and gives at most one output
// beat: the smallest head as soon as every taking-part source holds a head or has
// ended, or, once all have ended, one empty beat with tlast set. Input beats pass
// through a two-entry queue into the merge stage, which applies the beat, compares
// all heads in a combinational compare tree and fills the output register; a beat
// is registered in the queue and its result in the output register. s_tready drops
// only while the output is stalled and the queue is full. There is no clearing pass
// after reset. After the tlast beat further input is taken and discarded until
// reset.
module timestamp_kway_merge import tkm_pkg::*; #(
	parameter int SOURCES    = 8,
	parameter int FIELD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// record stream in
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// in_timestamp, in_token, in_bid_price, in_bid_qty,
	// in_ask_price, in_ask_qty, in_trade_price, in_trade_qty
	input  logic [NUM_FIELDS*FIELD_BITS-1:0] s_tdata,
	// req_type, source_index
	input  logic [S_USER_W-1:0]              s_tuser,
	// merged stream out
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_timestamp, out_token, out_bid_price, out_bid_qty,
	// out_ask_price, out_ask_qty, out_trade_price, out_trade_qty
	output logic [NUM_FIELDS*FIELD_BITS-1:0] m_tdata,
	// has_record, out_source
	output logic [M_USER_W-1:0]              m_tuser,
	// merge_done
	output logic                             m_tlast,
	// register port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [APB_AW-1:0]                paddr,
	input  logic [APB_DW-1:0]                pwdata,
	output logic [APB_DW-1:0]                prdata,
	output logic                             pready
);

	localparam int CNT_W = $clog2(SOURCES + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [CFG_W-1:0] active_q;
	logic [CMP_W-1:0] live_count;
	logic [CMP_W-1:0] active_ext;
	logic             reg_sel;
	item_ctl_t        q_ctl;
	logic             q_valid;
	logic             q_pop;
	logic [NUM_FIELDS*FIELD_BITS-1:0] q_data;
	logic [CMP_W-1:0] out_src_ext;

	// register access
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1] == REG_ACTIVE_SOURCES);
	assign prdata  = reg_sel ? APB_DW'(active_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACTIVE_RESET;
		end else if (psel & penable & pwrite & pready & reg_sel) begin
			active_q <= pwdata[CFG_W-1:0];
		end
	end

	// clamp the source count to 1..SOURCES
	assign active_ext = CMP_W'(active_q);

	always_comb begin
		if (active_ext == '0) begin
			live_count = CMP_W'(1);
		end else if (active_ext > CMP_W'(SOURCES)) begin
			live_count = CMP_W'(SOURCES);
		end else begin
			live_count = active_ext;
		end
	end

	tkm_front #(
		.FIELD_BITS (FIELD_BITS),
		.CMP_W      (CMP_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.live_count (live_count),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_valid    (q_valid),
		.q_ctl      (q_ctl),
		.q_data     (q_data),
		.q_pop      (q_pop)
	);

	tkm_back #(
		.SOURCES    (SOURCES),
		.FIELD_BITS (FIELD_BITS),
		.CMP_W      (CMP_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.live_count (live_count),
		.q_valid    (q_valid),
		.q_ctl      (q_ctl),
		.q_data     (q_data),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	// source of the beat on the output, widened for the live count compare
	assign out_src_ext = CMP_W'(m_tuser[M_USER_W-1:1]);

	// a beat carries either a record or the done mark, never both nor neither
	`TKM_ASSERT_NOW(a_record_xor_done, m_tvalid, m_tuser[0] != m_tlast, "record and done mixed")
	// an emitted record comes from a taking-part source
	`TKM_ASSERT_NOW(a_source_live, m_tvalid && m_tuser[0], out_src_ext < live_count, "inactive source")
	// nothing follows the done beat
	`TKM_ASSERT_NEXT(a_silent_after_done, m_tvalid && m_tready && m_tlast, !m_tvalid, "beat after done")

endmodule
